// ===== rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg: shared definitions for the first-fit allocator
// Sizes, codes, table entry layout and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

   localparam int REGION_BYTES = 16384;
   localparam int HEADER_BYTES = 16;
   localparam int MAX_BLOCKS   = 64;

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int SIZE_W = $clog2(REGION_BYTES + 1);
   localparam int REQ_W  = 15;
   localparam int ADDR_W = 14;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NO_FIT      = 2'd1,
      ST_BAD_ADDRESS = 2'd2
   } status_type;

   typedef struct packed {
      logic              in_use;
      logic [SIZE_W-1:0] size;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_FREE_R,
      S_SHIFT,
      S_TAIL
   } state_type;

   // commands from the sequencer to the arithmetic unit
   typedef struct packed {
      logic clear;
      logic advance;
      logic capture;
   } walk_ctl_type;

   // results of the arithmetic unit for the entry on the read port
   typedef struct packed {
      logic              fit;
      logic              split_ok;
      logic              match;
      logic [ADDR_W-1:0] grant_addr;
      logic [SIZE_W-1:0] tail_size;
      logic              prev_use;
      logic [SIZE_W-1:0] cur_size;
      logic [SIZE_W-1:0] merge_r;
      logic [SIZE_W-1:0] merge_l;
      logic [SIZE_W-1:0] merge_lr;
   } walk_stat_type;

endpackage

`default_nettype wire

// ===== rtl/first_fit_allocator_coalescing_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_allocator_coalescing_unit: first-fit heap allocator with merging
// Block table in RAM, walked one entry a cycle; inserts and merges move
// the tail of the table one entry a cycle.
// ----------------------------------------------------------------------------
// Busy from acceptance to the response strobe, set by the single RAM port
//   pair; one transaction at a time.
// Reset: synchronous; after reset the initial free block is written into
//   the table in S_INIT, busy high. Responses cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_allocator_coalescing_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_kind,
   input  wire logic [ffa_pkg::REQ_W-1:0]  req_request_bytes,
   input  wire logic [ffa_pkg::ADDR_W-1:0] req_payload_address,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic [ffa_pkg::ADDR_W-1:0]      rsp_granted_address
);

   localparam int IDX_W  = ffa_pkg::IDX_W;
   localparam int CNT_W  = ffa_pkg::CNT_W;
   localparam int SIZE_W = ffa_pkg::SIZE_W;
   localparam int ADDR_W = ffa_pkg::ADDR_W;

   localparam logic [SIZE_W-1:0] INIT_SIZE =
      SIZE_W'(ffa_pkg::REGION_BYTES - ffa_pkg::HEADER_BYTES);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(ffa_pkg::MAX_BLOCKS);

   // sequencer state
   ffa_pkg::state_type  state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;       // entry under examination
   logic [CNT_W-1:0]    count_ff, count_in;   // valid table entries

   // latched transaction
   logic                       kind_ff, kind_in;
   logic [ffa_pkg::REQ_W-1:0]  req_ff, req_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;

   // table move engine
   logic [IDX_W-1:0]  src_ff, src_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_dst_ff, pend_dst_in;
   logic              up_ff, up_in;
   logic              two_ff, two_in;
   logic              tail_pend_ff, tail_pend_in;
   logic [SIZE_W-1:0] tail_size_ff, tail_size_in;
   logic [ADDR_W-1:0] res_grant_ff, res_grant_in;

   // response registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   // RAM ports
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   ffa_pkg::entry_type  wr_data;
   logic [IDX_W-1:0]    rd_addr;
   logic [ffa_pkg::ENTRY_W-1:0] rd_raw;
   ffa_pkg::entry_type  rd_entry;

   ffa_pkg::walk_ctl_type  walk_ctl;
   ffa_pkg::walk_stat_type walk_stat;

   // helpers
   logic [CNT_W-1:0] idx_ext;
   logic             last_entry;
   logic             right_free;
   logic             left_free;
   logic             do_split;
   logic [CNT_W-1:0] cnt_minus_one;

   assign rd_entry = ffa_pkg::entry_type'(rd_raw);

   ffa_ram #(
      .WIDTH (ffa_pkg::ENTRY_W),
      .DEPTH (ffa_pkg::MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   ffa_walk u_walk (
      .clock           (clock),
      .ctl             (walk_ctl),
      .rd_entry        (rd_entry),
      .req_bytes       (req_ff),
      .payload_address (addr_ff),
      .stat            (walk_stat)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffa_pkg::S_INIT;
         count_ff     <= CNT_W'(1);
         pend_ff      <= 1'b0;
         tail_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         tail_pend_ff <= tail_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      kind_ff       <= kind_in;
      req_ff        <= req_in;
      addr_ff       <= addr_in;
      src_ff        <= src_in;
      cnt_ff        <= cnt_in;
      pend_dst_ff   <= pend_dst_in;
      up_ff         <= up_in;
      two_ff        <= two_in;
      tail_size_ff  <= tail_size_in;
      res_grant_ff  <= res_grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_addr_ff;

   always_comb begin
      // defaults: hold state, clear strobes, RAM quiet, prefetch next entry
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      kind_in       = kind_ff;
      req_in        = req_ff;
      addr_in       = addr_ff;
      src_in        = src_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      pend_dst_in   = pend_dst_ff;
      up_in         = up_ff;
      two_in        = two_ff;
      tail_pend_in  = tail_pend_ff;
      tail_size_in  = tail_size_ff;
      res_grant_in  = res_grant_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = '0;
      rd_addr       = idx_ff + IDX_W'(1);
      walk_ctl      = '0;
      busy          = 1'b1;

      idx_ext       = {{(CNT_W-IDX_W){1'b0}}, idx_ff};
      last_entry    = (idx_ext + CNT_W'(1)) == count_ff;
      right_free    = !last_entry && !rd_entry.in_use;
      left_free     = (idx_ff != '0) && !walk_stat.prev_use;
      do_split      = walk_stat.split_ok && (count_ff < MAX_CNT);
      cnt_minus_one = count_ff - CNT_W'(1);

      unique case (state_ff)
         ffa_pkg::S_INIT: begin
            // place the single free block that spans the region
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '{in_use: 1'b0, size: INIT_SIZE};
            state_in = ffa_pkg::S_IDLE;
         end

         ffa_pkg::S_IDLE: begin
            busy           = 1'b0;
            rd_addr        = '0;
            walk_ctl.clear = 1'b1;
            if (start) begin
               kind_in  = req_kind;
               req_in   = req_request_bytes;
               addr_in  = req_payload_address;
               idx_in   = '0;
               state_in = ffa_pkg::S_SCAN;
            end
         end

         ffa_pkg::S_SCAN: begin
            // rd_entry holds entry idx; entry idx+1 is being fetched
            if (kind_ff == ffa_pkg::KIND_ALLOC) begin
               if (walk_stat.fit) begin
                  wr_en = 1'b1;
                  if (do_split) begin
                     wr_data      = '{in_use: 1'b1, size: SIZE_W'(req_ff)};
                     count_in     = count_ff + CNT_W'(1);
                     tail_pend_in = 1'b1;
                     tail_size_in = walk_stat.tail_size;
                     res_grant_in = walk_stat.grant_addr;
                     // open a hole at idx+1: move entries idx+1 .. count-1 up
                     up_in        = 1'b1;
                     two_in       = 1'b0;
                     src_in       = cnt_minus_one[IDX_W-1:0];
                     cnt_in       = count_ff - idx_ext - CNT_W'(1);
                     state_in     = ffa_pkg::S_SHIFT;
                  end else begin
                     wr_data       = '{in_use: 1'b1, size: rd_entry.size};
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ffa_pkg::ST_OK;
                     rsp_addr_in   = walk_stat.grant_addr;
                     state_in      = ffa_pkg::S_IDLE;
                  end
               end else if (last_entry) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ffa_pkg::ST_NO_FIT;
                  rsp_addr_in   = '0;
                  state_in      = ffa_pkg::S_IDLE;
               end else begin
                  walk_ctl.advance = 1'b1;
                  idx_in           = idx_ff + IDX_W'(1);
               end
            end else begin
               if (walk_stat.match) begin
                  if (rd_entry.in_use) begin
                     walk_ctl.capture = 1'b1;
                     state_in         = ffa_pkg::S_FREE_R;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ffa_pkg::ST_BAD_ADDRESS;
                     rsp_addr_in   = '0;
                     state_in      = ffa_pkg::S_IDLE;
                  end
               end else if (last_entry) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ffa_pkg::ST_BAD_ADDRESS;
                  rsp_addr_in   = '0;
                  state_in      = ffa_pkg::S_IDLE;
               end else begin
                  walk_ctl.advance = 1'b1;
                  idx_in           = idx_ff + IDX_W'(1);
               end
            end
         end

         ffa_pkg::S_FREE_R: begin
            // rd_entry is the right neighbour (if any); merge and close gaps
            wr_en        = 1'b1;
            tail_pend_in = 1'b0;
            res_grant_in = '0;
            up_in        = 1'b0;
            priority if (left_free && right_free) begin
               wr_addr  = idx_ff - IDX_W'(1);
               wr_data  = '{in_use: 1'b0, size: walk_stat.merge_lr};
               count_in = count_ff - CNT_W'(2);
               two_in   = 1'b1;
               src_in   = idx_ff + IDX_W'(2);
               cnt_in   = count_ff - idx_ext - CNT_W'(2);
               state_in = ffa_pkg::S_SHIFT;
            end else if (left_free) begin
               wr_addr  = idx_ff - IDX_W'(1);
               wr_data  = '{in_use: 1'b0, size: walk_stat.merge_l};
               count_in = cnt_minus_one;
               two_in   = 1'b0;
               src_in   = idx_ff + IDX_W'(1);
               cnt_in   = count_ff - idx_ext - CNT_W'(1);
               state_in = ffa_pkg::S_SHIFT;
            end else if (right_free) begin
               wr_data  = '{in_use: 1'b0, size: walk_stat.merge_r};
               count_in = cnt_minus_one;
               two_in   = 1'b0;
               src_in   = idx_ff + IDX_W'(2);
               cnt_in   = count_ff - idx_ext - CNT_W'(2);
               state_in = ffa_pkg::S_SHIFT;
            end else begin
               // no free neighbour: the block keeps its size
               wr_data       = '{in_use: 1'b0, size: walk_stat.cur_size};
               rsp_valid_in  = 1'b1;
               rsp_status_in = ffa_pkg::ST_OK;
               rsp_addr_in   = '0;
               state_in      = ffa_pkg::S_IDLE;
            end
         end

         ffa_pkg::S_SHIFT: begin
            // pipelined move: read src this cycle, write its data next cycle
            rd_addr = src_ff;
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_dst_ff;
               wr_data = rd_entry;
            end
            if (cnt_ff != '0) begin
               pend_in     = 1'b1;
               pend_dst_in = up_ff ? (src_ff + IDX_W'(1))
                                   : (src_ff - (two_ff ? IDX_W'(2) : IDX_W'(1)));
               src_in      = up_ff ? (src_ff - IDX_W'(1)) : (src_ff + IDX_W'(1));
               cnt_in      = cnt_ff - CNT_W'(1);
            end else if (tail_pend_ff) begin
               state_in = ffa_pkg::S_TAIL;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ffa_pkg::ST_OK;
               rsp_addr_in   = res_grant_ff;
               state_in      = ffa_pkg::S_IDLE;
            end
         end

         ffa_pkg::S_TAIL: begin
            // new free remainder behind the split block
            wr_en         = 1'b1;
            wr_addr       = idx_ff + IDX_W'(1);
            wr_data       = '{in_use: 1'b0, size: tail_size_ff};
            tail_pend_in  = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ffa_pkg::ST_OK;
            rsp_addr_in   = res_grant_ff;
            state_in      = ffa_pkg::S_IDLE;
         end

         default: begin
            state_in = ffa_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/ffa_walk.sv =====
// ----------------------------------------------------------------------------
// ffa_walk: shared arithmetic unit of the allocator
// Running header offset, fit and address compares, split and merge sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_walk (
   input  wire logic                       clock,
   input  wire ffa_pkg::walk_ctl_type      ctl,
   input  wire ffa_pkg::entry_type         rd_entry,
   input  wire logic [ffa_pkg::REQ_W-1:0]  req_bytes,
   input  wire logic [ffa_pkg::ADDR_W-1:0] payload_address,
   output ffa_pkg::walk_stat_type          stat
);

   localparam logic [ffa_pkg::SIZE_W-1:0] HDR = ffa_pkg::SIZE_W'(ffa_pkg::HEADER_BYTES);

   logic [ffa_pkg::SIZE_W-1:0] hdr_ff, hdr_in;
   logic                       prev_use_ff, prev_use_in;
   logic [ffa_pkg::SIZE_W-1:0] prev_size_ff, prev_size_in;
   logic [ffa_pkg::SIZE_W-1:0] cur_size_ff, cur_size_in;
   logic [ffa_pkg::SIZE_W-1:0] payload_off;
   logic [ffa_pkg::SIZE_W-1:0] rest;

   always_ff @(posedge clock) begin
      hdr_ff       <= hdr_in;
      prev_use_ff  <= prev_use_in;
      prev_size_ff <= prev_size_in;
      cur_size_ff  <= cur_size_in;
   end

   always_comb begin
      hdr_in       = hdr_ff;
      prev_use_in  = prev_use_ff;
      prev_size_in = prev_size_ff;
      cur_size_in  = cur_size_ff;
      if (ctl.clear) begin
         hdr_in = '0;
      end else if (ctl.advance) begin
         hdr_in       = hdr_ff + HDR + rd_entry.size;
         prev_use_in  = rd_entry.in_use;
         prev_size_in = rd_entry.size;
      end
      if (ctl.capture) begin
         cur_size_in = rd_entry.size;
      end
   end

   always_comb begin
      payload_off     = hdr_ff + HDR;
      // only meaningful when the entry fits, so never negative
      rest            = rd_entry.size - ffa_pkg::SIZE_W'(req_bytes);
      stat.fit        = !rd_entry.in_use && (32'(rd_entry.size) >= 32'(req_bytes));
      stat.split_ok   = (rest >= HDR);
      stat.tail_size  = rest - HDR;
      stat.match      = (32'(payload_off) == 32'(payload_address));
      stat.grant_addr = payload_off[ffa_pkg::ADDR_W-1:0];
      stat.prev_use   = prev_use_ff;
      stat.cur_size   = cur_size_ff;
      stat.merge_r    = cur_size_ff + HDR + rd_entry.size;
      stat.merge_l    = prev_size_ff + HDR + cur_size_ff;
      stat.merge_lr   = prev_size_ff + cur_size_ff + rd_entry.size + HDR + HDR;
   end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the first-fit allocator
// Drives allocate and free transactions on the start/busy command port and
// predicts each reply from its own copy of the block table. A short table
// of directed transactions covers the corners; random fill and drain cycles
// follow under three sender idling profiles. Every reply is checked field by
// field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS;
   localparam int HEADER_BYTES = ffa_pkg::HEADER_BYTES;
   localparam int REGION_BYTES = ffa_pkg::REGION_BYTES;
   localparam int REQ_W        = ffa_pkg::REQ_W;
   localparam int ADDR_W       = ffa_pkg::ADDR_W;
   localparam int SIZE_W       = ffa_pkg::SIZE_W;

   // cycles without any handshake or reply before the run is abandoned
   localparam int QUIET_LIMIT = 4000;
   // worst walk plus worst table move, with margin
   localparam int DRAIN_CYCLES = 2 * MAX_BLOCKS + 8;
   localparam int RANDOM_PER_PHASE = 400;

   // one command transaction; want_* only used when typed is set
   typedef struct {
      logic                filled_kind;
      logic [REQ_W-1:0]    bytes;
      logic [ADDR_W-1:0]   addr;
      bit                  typed;
      ffa_pkg::status_type want_status;
      logic [ADDR_W-1:0]   want_addr;
   } heap_op_type;

   typedef struct {
      ffa_pkg::status_type status;
      logic [ADDR_W-1:0]   granted;
   } heap_reply_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_kind = ffa_pkg::KIND_ALLOC;
   logic [REQ_W-1:0]  req_request_bytes = '0;
   logic [ADDR_W-1:0] req_payload_address = '0;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [ADDR_W-1:0] rsp_granted_address;

   // predicted block table: payload size and in-use flag per entry
   logic [SIZE_W-1:0] heap_size [MAX_BLOCKS];
   bit                heap_used [MAX_BLOCKS];
   int                heap_count;

   heap_reply_type    expected_replies [$];
   heap_op_type       directed_ops [$];
   int                mismatch_count = 0;
   int                quiet_cycles = 0;

   // random part alternates between filling the heap and draining it
   bit                filling = 1'b1;
   int                fill_target = 40;

   first_fit_allocator_coalescing_unit dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_request_bytes   (req_request_bytes),
      .req_payload_address (req_payload_address),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
   endtask

   // remove entry idx, closing the gap from above
   function automatic void drop_slot(input int idx);
      int k;
      for (k = idx; k + 1 < heap_count; k++) begin
         heap_size[k] = heap_size[k + 1];
         heap_used[k] = heap_used[k + 1];
      end
      heap_count--;
      heap_size[heap_count] = '0;
      heap_used[heap_count] = 1'b0;
   endfunction

   // expected reply of one transaction; updates the predicted table
   function automatic heap_reply_type heap_apply(input heap_op_type t);
      heap_reply_type r;
      int             hit;
      int             hdr;
      int             rest;
      int             i;
      r.status  = ffa_pkg::ST_OK;
      r.granted = '0;
      hit = -1;
      hdr = 0;
      if (t.filled_kind == ffa_pkg::KIND_ALLOC) begin
         // first free block big enough, header offset summed on the way
         for (i = 0; i < heap_count && hit < 0; i++) begin
            if (!heap_used[i] && int'(heap_size[i]) >= int'(t.bytes))
               hit = i;
            else
               hdr += HEADER_BYTES + int'(heap_size[i]);
         end
         if (hit < 0) begin
            r.status = ffa_pkg::ST_NO_FIT;
         end else begin
            rest = int'(heap_size[hit]) - int'(t.bytes);
            // split only when the remainder holds a header and a slot is spare
            if (rest >= HEADER_BYTES && heap_count < MAX_BLOCKS) begin
               for (i = heap_count; i > hit + 1; i--) begin
                  heap_size[i] = heap_size[i - 1];
                  heap_used[i] = heap_used[i - 1];
               end
               heap_size[hit + 1] = SIZE_W'(rest - HEADER_BYTES);
               heap_used[hit + 1] = 1'b0;
               heap_size[hit]     = t.bytes;
               heap_count++;
            end
            heap_used[hit] = 1'b1;
            // a zero block at the very top wraps to offset zero
            r.granted = ADDR_W'(hdr + HEADER_BYTES);
         end
      end else begin
         for (i = 0; i < heap_count && hit < 0; i++) begin
            if (hdr + HEADER_BYTES == int'(t.addr))
               hit = i;
            else
               hdr += HEADER_BYTES + int'(heap_size[i]);
         end
         if (hit < 0 || !heap_used[hit]) begin
            r.status = ffa_pkg::ST_BAD_ADDRESS;
         end else begin
            heap_used[hit] = 1'b0;
            // right neighbour first, then the left one absorbs the result
            if (hit + 1 < heap_count && !heap_used[hit + 1]) begin
               heap_size[hit] = SIZE_W'(int'(heap_size[hit]) + HEADER_BYTES
                                        + int'(heap_size[hit + 1]));
               drop_slot(hit + 1);
            end
            if (hit > 0 && !heap_used[hit - 1]) begin
               heap_size[hit - 1] = SIZE_W'(int'(heap_size[hit - 1]) + HEADER_BYTES
                                            + int'(heap_size[hit]));
               drop_slot(hit);
            end
         end
      end
      return r;
   endfunction

   function automatic heap_op_type heap_row(input logic kind, input int bytes,
                                            input int addr, input bit typed,
                                            input ffa_pkg::status_type st,
                                            input int granted);
      heap_op_type t;
      t.filled_kind = kind;
      t.bytes       = REQ_W'(bytes);
      t.addr        = ADDR_W'(addr);
      t.typed       = typed;
      t.want_status = st;
      t.want_addr   = ADDR_W'(granted);
      return t;
   endfunction

   // next random transaction, shaped by the predicted table
   function automatic heap_op_type random_op();
      heap_op_type t;
      int          used_n;
      int          free_bytes;
      int          pick;
      int          size_pick;
      int          k;
      int          seen;
      int          jitter;
      int          hdr;
      int          i;
      t = heap_row(ffa_pkg::KIND_FREE, $urandom_range(0, 32767), $urandom_range(0, 16383),
                   1'b0, ffa_pkg::ST_OK, 0);
      used_n     = 0;
      free_bytes = 0;
      k          = 0;
      jitter     = 0;
      for (i = 0; i < heap_count; i++) begin
         if (heap_used[i])
            used_n++;
         else
            free_bytes += int'(heap_size[i]);
      end
      if (filling && (used_n >= fill_target || free_bytes < 64))
         filling = 1'b0;
      if (!filling && used_n == 0) begin
         filling     = 1'b1;
         fill_target = $urandom_range(8, MAX_BLOCKS + 16);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8)
         return t;   // arbitrary address: nearly always rejected
      if (pick < 14) begin
         // any block, live or already free, sometimes a little off its payload
         k = $urandom_range(0, heap_count - 1);
         if (pick >= 11)
            jitter = $urandom_range(0, 32) - 16;
      end else if (used_n == 0 || $urandom_range(0, 99) < (filling ? 75 : 25)) begin
         t.filled_kind = ffa_pkg::KIND_ALLOC;
         size_pick     = $urandom_range(0, 99);
         if (size_pick < 70)
            t.bytes = REQ_W'($urandom_range(0, 64));
         else if (size_pick < 88)
            t.bytes = REQ_W'($urandom_range(0, 1024));
         else if (size_pick < 96)
            t.bytes = REQ_W'($urandom_range(0, 16384));
         else
            t.bytes = REQ_W'($urandom_range(0, 32767));
         return t;
      end else begin
         // free a live block
         seen = $urandom_range(0, used_n - 1);
         for (i = 0; i < heap_count; i++) begin
            if (heap_used[i]) begin
               if (seen == 0)
                  k = i;
               seen--;
            end
         end
      end
      hdr = 0;
      for (i = 0; i < k; i++)
         hdr += HEADER_BYTES + int'(heap_size[i]);
      t.addr = ADDR_W'(hdr + HEADER_BYTES + jitter);
      return t;
   endfunction

   // present one transaction, wait for the handshake, queue its prediction
   task automatic issue_txn(input heap_op_type t, input int idle_pct);
      heap_reply_type r;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      start               <= 1'b1;
      req_kind            <= t.filled_kind;
      req_request_bytes   <= t.bytes;
      req_payload_address <= t.addr;
      do @(posedge clock); while (busy !== 1'b0);
      r = heap_apply(t);
      if (t.typed) begin
         r.status  = t.want_status;
         r.granted = t.want_addr;
      end
      expected_replies.push_back(r);
      // table full and nothing fits: time to drain
      if (r.status == ffa_pkg::ST_NO_FIT && heap_count == MAX_BLOCKS)
         filling = 1'b0;
   endtask

   // stimulus
   initial begin
      int k;
      int phase;
      int idle_pct;
      for (k = 0; k < MAX_BLOCKS; k++) begin
         heap_size[k] = '0;
         heap_used[k] = 1'b0;
      end
      heap_size[0] = SIZE_W'(REGION_BYTES - HEADER_BYTES);
      heap_count   = 1;

      // directed corners; typed rows are plain from the reset layout
      directed_ops.push_back(heap_row(ffa_pkg::KIND_ALLOC, 0,     0,     1,
                                      ffa_pkg::ST_OK,          16));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_ALLOC, 16384, 0,     1,
                                      ffa_pkg::ST_NO_FIT,      0));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_ALLOC, 32767, 16383, 1,
                                      ffa_pkg::ST_NO_FIT,      0));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_FREE,  0,     0,     1,
                                      ffa_pkg::ST_BAD_ADDRESS, 0));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_FREE,  32767, 16383, 1,
                                      ffa_pkg::ST_BAD_ADDRESS, 0));
      // free block left by the split: double free is rejected
      directed_ops.push_back(heap_row(ffa_pkg::KIND_FREE,  0,     32,    1,
                                      ffa_pkg::ST_BAD_ADDRESS, 0));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_FREE,  0,     16,    1,
                                      ffa_pkg::ST_OK,          0));
      // exact fit, then nothing left
      directed_ops.push_back(heap_row(ffa_pkg::KIND_ALLOC, 16368, 0,     1,
                                      ffa_pkg::ST_OK,          16));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_ALLOC, 0,     0,     1,
                                      ffa_pkg::ST_NO_FIT,      0));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_FREE,  0,     16,    1,
                                      ffa_pkg::ST_OK,          0));
      // remainder one short of a header: whole block granted
      directed_ops.push_back(heap_row(ffa_pkg::KIND_ALLOC, 16353, 0,     1,
                                      ffa_pkg::ST_OK,          16));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_FREE,  0,     16,    1,
                                      ffa_pkg::ST_OK,          0));
      // remainder exactly a header: zero-payload block at the top
      directed_ops.push_back(heap_row(ffa_pkg::KIND_ALLOC, 16352, 0,     1,
                                      ffa_pkg::ST_OK,          16));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_ALLOC, 0,     0,     0,
                                      ffa_pkg::ST_OK,          0));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_FREE,  0,     16,    0,
                                      ffa_pkg::ST_OK,          0));
      // three blocks, then free middle, left and right to exercise both merges
      directed_ops.push_back(heap_row(ffa_pkg::KIND_ALLOC, 100,   0,     0,
                                      ffa_pkg::ST_OK,          0));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_ALLOC, 200,   0,     0,
                                      ffa_pkg::ST_OK,          0));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_ALLOC, 300,   0,     0,
                                      ffa_pkg::ST_OK,          0));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_FREE,  0,     132,   0,
                                      ffa_pkg::ST_OK,          0));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_FREE,  0,     16,    0,
                                      ffa_pkg::ST_OK,          0));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_FREE,  0,     348,   0,
                                      ffa_pkg::ST_OK,          0));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_FREE,  0,     348,   1,
                                      ffa_pkg::ST_BAD_ADDRESS, 0));
      directed_ops.push_back(heap_row(ffa_pkg::KIND_FREE,  0,     16368, 0,
                                      ffa_pkg::ST_OK,          0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_ops[n])
         issue_txn(directed_ops[n], 10);

      // sender idles 10 %, then 70 %, then never
      for (phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 10 : (phase == 1) ? 70 : 0;
         repeat (RANDOM_PER_PHASE)
            issue_txn(random_op(), idle_pct);
      end

      start <= 1'b0;
      while (expected_replies.size() != 0)
         @(posedge clock);
      // stray replies after the last one still count
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // reply checker and watchdog; values sampled as they stood before the edge
   always @(posedge clock) begin
      heap_reply_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("reply with no transaction outstanding, status",
                               32'(rsp_status), 32'(0));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_granted_address !== want.granted)
                  report_mismatch("granted_address", 32'(rsp_granted_address),
                                  32'(want.granted));
            end
         end
         if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

endmodule

// ===== filelist.f =====
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/ffa_walk.sv
rtl/first_fit_allocator_coalescing_unit.sv
sim/tb_top.sv
